@@ design/hht_pkg.sv @@
// Shared types and constants for the hysteresis heater thermostat.
package hht_pkg;

  // Operation codes carried by an input word
  typedef enum logic [1:0] {
    OP_READ        = 2'd0,
    OP_FORCE_OFF   = 2'd1,
    OP_RESET_STATS = 2'd2,
    OP_UNUSED      = 2'd3
  } op_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_BAND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWITCH    = 3'd3;
  localparam int unsigned CFG_DATA_W = 32;

  // Temperatures in 1/16 C
  localparam logic signed [11:0] TEMP_DISCONNECTED = -12'sd2032;
  localparam logic signed [11:0] TEMP_CUTOFF       = 12'sd448;
  localparam logic signed [11:0] TEMP_BAD_85       = 12'sd1360;
  localparam logic signed [11:0] TEMP_RANGE_LOW    = -12'sd800;
  localparam logic signed [11:0] TEMP_RANGE_HIGH   = 12'sd800;
  localparam logic signed [11:0] STAT_MIN_RESET    = 12'sd1600;
  localparam logic signed [11:0] STAT_MAX_RESET    = -12'sd1600;

  // Hysteresis band limits
  localparam logic [6:0] HYST_LOW  = 7'd2;
  localparam logic [6:0] HYST_HIGH = 7'd80;

  // Configuration reset values
  localparam logic signed [10:0] TARGET_RESET   = 11'sd400;
  localparam logic [6:0]         HYST_RESET     = 7'd8;
  localparam logic [15:0]        READ_INT_RESET = 16'd1000;
  localparam logic [31:0]        MIN_SW_RESET   = 32'd60000;

  typedef struct packed {
    op_t                operation;
    logic [31:0]        now_ms;
    logic               device_present;
    logic signed [11:0] sample;
  } in_word_t;

  typedef struct packed {
    logic               heater_on;
    logic signed [11:0] temperature;
    logic signed [11:0] daily_min;
    logic signed [11:0] daily_max;
  } out_word_t;

endpackage

@@ design/hysteresis_heater_thermostat.sv @@
// Top level of the hysteresis heater thermostat: input register, control logic, result register.
//
//  channel | ports                          | word
//  --------+--------------------------------+---------------------------------------
//  input   | in_valid  in_ready  in_data    | in_word_t: operation, time, sample
//  result  | out_valid out_ready out_data   | out_word_t: heater, temperature, stats
//  config  | cfg_valid cfg_ready cfg_index  | cfg_data, 32 bit, always ready
//
// One word per cycle is sustained while results are taken. A word is captured in
// the input register; once the result register is free, the control logic updates
// the state and loads the result register from it, which then offers the result.
// A stalled result holds both registers; the input register still takes a word while
// it is empty. Reset (rst_n low, synchronous) empties both stages and restores the
// state and configuration defaults.
module hysteresis_heater_thermostat
  import hht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic signed [10:0] target_r;
  logic [6:0]         band_r;
  logic [15:0]        read_int_r;
  logic [31:0]        min_sw_r;
  logic [6:0]         band_wr;

  // Thermostat state
  logic [31:0]        last_read_r, last_read_nxt;
  logic               seen_r, seen_nxt;
  logic signed [11:0] held_r, held_nxt;
  logic               held_vld_r, held_vld_nxt;
  logic signed [11:0] min_r, min_nxt;
  logic signed [11:0] max_r, max_nxt;
  logic               heating_r, heating_nxt;
  logic [31:0]        last_sw_r, last_sw_nxt;

  // Pipeline registers
  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      out_vld_r;
  out_word_t out_word_r, out_word_nxt;

  logic      out_free;
  logic      fire;

  // Datapath terms
  logic [31:0]        read_age;
  logic [31:0]        switch_age;
  logic               read_due;
  logic               may_switch;
  logic               sample_ok;
  logic signed [12:0] held_ext;
  logic signed [12:0] target_ext;
  logic signed [12:0] band_ext;
  logic signed [12:0] on_level;
  logic signed [12:0] off_level;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || out_ready;
  assign fire      = in_vld_r && out_free;
  assign in_ready  = !in_vld_r || out_free;
  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  // Clamp a band write into the legal range
  always_comb begin
    band_wr = cfg_data[6:0];
    if (band_wr < HYST_LOW) begin
      band_wr = HYST_LOW;
    end else if (band_wr > HYST_HIGH) begin
      band_wr = HYST_HIGH;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= TARGET_RESET;
      band_r     <= HYST_RESET;
      read_int_r <= READ_INT_RESET;
      min_sw_r   <= MIN_SW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_TEMP:   target_r   <= $signed(cfg_data[10:0]);
        CFG_HYST_BAND:     band_r     <= band_wr;
        CFG_READ_INTERVAL: read_int_r <= cfg_data[15:0];
        CFG_MIN_SWITCH:    min_sw_r   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Elapsed times and sample validation
  assign read_age   = in_word_r.now_ms - last_read_r;
  assign switch_age = in_word_r.now_ms - last_sw_r;
  assign read_due   = read_age >= {16'd0, read_int_r};
  assign may_switch = switch_age >= min_sw_r;
  assign sample_ok  = (in_word_r.sample != TEMP_DISCONNECTED)
                   && (in_word_r.sample != TEMP_BAD_85)
                   && (in_word_r.sample > TEMP_RANGE_LOW)
                   && (in_word_r.sample < TEMP_RANGE_HIGH);

  // Switching thresholds around the setpoint
  assign target_ext = {{2{target_r[10]}}, target_r};
  assign band_ext   = {6'd0, band_r};
  assign on_level   = target_ext - band_ext;
  assign off_level  = target_ext + band_ext;
  assign held_ext   = {held_nxt[11], held_nxt};

  // Next state: sensor read, then heater control on the held value; forced off; stats reset
  always_comb begin
    last_read_nxt = last_read_r;
    seen_nxt      = seen_r;
    held_nxt      = held_r;
    held_vld_nxt  = held_vld_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    heating_nxt   = heating_r;
    last_sw_nxt   = last_sw_r;

    case (in_word_r.operation)
      OP_READ: begin
        if (read_due) begin
          last_read_nxt = in_word_r.now_ms;
          if (!seen_r && !in_word_r.device_present) begin
            seen_nxt = 1'b0;
          end else if (sample_ok) begin
            seen_nxt     = 1'b1;
            held_nxt     = in_word_r.sample;
            held_vld_nxt = 1'b1;
            if (in_word_r.sample < min_r) begin
              min_nxt = in_word_r.sample;
            end
            if (in_word_r.sample > max_r) begin
              max_nxt = in_word_r.sample;
            end
          end else begin
            seen_nxt = in_word_r.device_present;
          end
        end
        if (held_vld_nxt) begin
          if (held_nxt >= TEMP_CUTOFF) begin
            if (heating_r) begin
              heating_nxt = 1'b0;
              last_sw_nxt = in_word_r.now_ms;
            end
          end else if (!heating_r && held_ext <= on_level) begin
            if (may_switch) begin
              heating_nxt = 1'b1;
              last_sw_nxt = in_word_r.now_ms;
            end
          end else if (heating_r && held_ext >= off_level) begin
            if (may_switch) begin
              heating_nxt = 1'b0;
              last_sw_nxt = in_word_r.now_ms;
            end
          end
        end
      end
      OP_FORCE_OFF: begin
        heating_nxt = 1'b0;
        last_sw_nxt = in_word_r.now_ms;
      end
      OP_RESET_STATS: begin
        min_nxt = in_word_r.sample;
        max_nxt = in_word_r.sample;
      end
      default: ;
    endcase
  end

  // Assemble the result word
  always_comb begin
    out_word_nxt.heater_on   = heating_nxt;
    out_word_nxt.temperature = held_vld_nxt ? held_nxt : TEMP_DISCONNECTED;
    out_word_nxt.daily_min   = min_nxt;
    out_word_nxt.daily_max   = max_nxt;
  end

  // Advance the state on each processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_read_r <= '0;
      seen_r      <= 1'b0;
      held_r      <= '0;
      held_vld_r  <= 1'b0;
      min_r       <= STAT_MIN_RESET;
      max_r       <= STAT_MAX_RESET;
      heating_r   <= 1'b0;
      last_sw_r   <= '0;
    end else if (fire) begin
      last_read_r <= last_read_nxt;
      seen_r      <= seen_nxt;
      held_r      <= held_nxt;
      held_vld_r  <= held_vld_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      heating_r   <= heating_nxt;
      last_sw_r   <= last_sw_nxt;
    end
  end

  // Hold or advance the input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
    if (fire) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

@@ design/hht_checker.sv @@
// Port-level checks for the hysteresis heater thermostat, bound to the top level.
module hht_port_checks
  import hht_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Heater is never on at or above the cutoff
  a_cutoff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($signed(out_data.temperature) >= TEMP_CUTOFF) |-> !out_data.heater_on)
    else $error("heater on at or above cutoff");

  // Shown temperature is either the no-reading marker or a valid sample
  a_temp_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.temperature != TEMP_DISCONNECTED) |->
      ($signed(out_data.temperature) > TEMP_RANGE_LOW)
      && ($signed(out_data.temperature) < TEMP_RANGE_HIGH)
      && (out_data.temperature != TEMP_BAD_85))
    else $error("held temperature outside the valid range");

endmodule

bind hysteresis_heater_thermostat hht_port_checks u_hht_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
